// ===== rtl/core/sdpg_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpg_pkg
// Shared types and constants of the step/direction pulse generator.
// ----------------------------------------------------------------------------
package sdpg_pkg;

    localparam int PW_W       = 8;
    localparam int SETTLE_W   = 16;
    localparam int ACTION_W   = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;
    localparam int FLAG_BITS  = 6;

    localparam logic [PW_W-1:0]     PW_RESET     = 8'd5;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1000;
    localparam logic                FWD_RESET    = 1'b1;

    // Register indexes, byte address = 4 * index.
    localparam logic [REG_IDX_W-1:0] REG_PULSE_WIDTH     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE_TIME     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FORWARD_IS_HIGH = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 3'd0,
        ACT_START     = 3'd1,
        ACT_STOP      = 3'd2,
        ACT_ENABLE    = 3'd3,
        ACT_DISABLE   = 3'd4,
        ACT_TAKE_DONE = 3'd5
    } action_t;

    typedef struct packed {
        logic [PW_W-1:0]     pulse_width;
        logic [SETTLE_W-1:0] settle_time;
        logic                forward_is_high;
    } sdpg_cfg_t;

endpackage

// ===== rtl/core/step_dir_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// step_dir_pulse_generator
// Step/direction pulse generator: commands and one-microsecond ticks in,
// one status word out per command.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         tuser: action; tdata: move_reverse, pulse_count, step_interval
//  m_*       out        tdata: step/dir/enable/busy/accepted/done flags, steps_done
//  APB       in/out     pulse_width @0x0, settle_time @0x4, forward_is_high @0x8
//
// One word per clock is sustained while m_tready stays high. A word passes
// through the input register, and its status is registered in the result
// register. Reset (synchronous, aresetn low) clears the move state and loads
// the register defaults. A stalled m_tready holds the result and, one word
// later, the input register, which then deasserts s_tready.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator
    import sdpg_pkg::*;
#(
    parameter int COUNT_WIDTH = 24,
    parameter int TIME_WIDTH  = 16,
    localparam int IN_BITS    = 1 + COUNT_WIDTH + TIME_WIDTH,
    localparam int S_DATA_W   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = FLAG_BITS + COUNT_WIDTH,
    localparam int M_DATA_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: move_reverse, pulse_count, step_interval, zero padding.
    input  logic [S_DATA_W-1:0]   s_tdata,
    // action
    input  logic [ACTION_W-1:0]   s_tuser,
    // Status stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: step_out, dir_out, enable_out, busy_res, accepted,
    // move_done, steps_done, zero padding.
    output logic [M_DATA_W-1:0]   m_tdata
);

    sdpg_cfg_t           cfg;
    logic                core_ready;
    logic                item_valid;
    logic [IN_BITS-1:0]  item_data;
    logic [ACTION_W-1:0] item_user;
    logic [OUT_BITS-1:0] res_data;

    sdpg_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdpg_in_stage #(
        .DATA_W (S_DATA_W),
        .ITEM_W (IN_BITS)
    ) u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .core_ready (core_ready),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_user  (item_user)
    );

    sdpg_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .ITEM_W      (IN_BITS),
        .RES_W       (OUT_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_user  (item_user),
        .core_ready (core_ready),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_data   (res_data)
    );

    assign m_tdata = M_DATA_W'(res_data);

endmodule

// ===== rtl/core/sdpg_apb_regs.sv =====
// ----------------------------------------------------------------------------
// sdpg_apb_regs
// APB register file holding pulse width, settle time and direction polarity.
// ----------------------------------------------------------------------------
module sdpg_apb_regs
    import sdpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output sdpg_cfg_t             cfg
);

    sdpg_cfg_t             cfg_reg;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_width     <= PW_RESET;
            cfg_reg.settle_time     <= SETTLE_RESET;
            cfg_reg.forward_is_high <= FWD_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PULSE_WIDTH:     cfg_reg.pulse_width     <= pwdata[PW_W-1:0];
                REG_SETTLE_TIME:     cfg_reg.settle_time     <= pwdata[SETTLE_W-1:0];
                REG_FORWARD_IS_HIGH: cfg_reg.forward_is_high <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PULSE_WIDTH:     prdata = APB_DATA_W'(cfg_reg.pulse_width);
            REG_SETTLE_TIME:     prdata = APB_DATA_W'(cfg_reg.settle_time);
            REG_FORWARD_IS_HIGH: prdata = APB_DATA_W'(cfg_reg.forward_is_high);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/sdpg_in_stage.sv =====
// ----------------------------------------------------------------------------
// sdpg_in_stage
// Input register for command words; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module sdpg_in_stage
    import sdpg_pkg::*;
#(
    parameter int DATA_W   = 48,
    parameter int ITEM_W   = 41
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,
    input  logic [ACTION_W-1:0] s_tuser,
    input  logic                core_ready,
    output logic                item_valid,
    output logic [ITEM_W-1:0]   item_data,
    output logic [ACTION_W-1:0] item_user
);

    logic                valid_reg;
    logic [ITEM_W-1:0]   data_reg;
    logic [ACTION_W-1:0] user_reg;

    // The held word leaves exactly when the core can take a result.
    assign s_tready   = !valid_reg || core_ready;
    assign item_valid = valid_reg;
    assign item_data  = data_reg;
    assign item_user  = user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata[ITEM_W-1:0];
            user_reg <= s_tuser;
        end
    end

endmodule

// ===== rtl/core/sdpg_core.sv =====
// ----------------------------------------------------------------------------
// sdpg_core
// Move state, step countdown and pulse counters, plus the result register.
// ----------------------------------------------------------------------------
module sdpg_core
    import sdpg_pkg::*;
#(
    parameter int COUNT_WIDTH = 24,
    parameter int TIME_WIDTH  = 16,
    parameter int ITEM_W      = 41,
    parameter int RES_W       = 30
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sdpg_cfg_t           cfg,
    input  logic                item_valid,
    input  logic [ITEM_W-1:0]   item_data,
    input  logic [ACTION_W-1:0] item_user,
    output logic                core_ready,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [RES_W-1:0]    res_data
);

    logic                   busy_reg, busy_next;
    logic                   enabled_reg, enabled_next;
    logic                   step_reg, step_next;
    logic                   done_reg, done_next;
    logic                   rev_reg, rev_next;
    logic [COUNT_WIDTH-1:0] req_reg, req_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [TIME_WIDTH-1:0]  ivl_reg, ivl_next;
    logic [TIME_WIDTH-1:0]  cdn_reg, cdn_next;

    logic                   out_valid_reg;
    logic [RES_W-1:0]       out_data_reg;

    logic                   take;
    logic                   accepted;
    logic                   done_out;
    action_t                action;
    logic                   move_reverse;
    logic [COUNT_WIDTH-1:0] pulse_count;
    logic [TIME_WIDTH-1:0]  step_interval;
    logic [TIME_WIDTH+PW_W-1:0]     pw_wide;
    logic [TIME_WIDTH+SETTLE_W-1:0] settle_wide;
    logic [TIME_WIDTH-1:0]  pw_t;
    logic [TIME_WIDTH-1:0]  settle_t;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    assign action        = action_t'(item_user);
    assign move_reverse  = item_data[0];
    assign pulse_count   = item_data[COUNT_WIDTH:1];
    assign step_interval = item_data[COUNT_WIDTH+TIME_WIDTH:COUNT_WIDTH+1];

    // Zero-extend first, then keep the low bits, so narrow time widths truncate.
    assign pw_wide     = {{TIME_WIDTH{1'b0}}, cfg.pulse_width};
    assign settle_wide = {{TIME_WIDTH{1'b0}}, cfg.settle_time};
    assign pw_t        = pw_wide[TIME_WIDTH-1:0];
    assign settle_t    = settle_wide[TIME_WIDTH-1:0];
    assign cnt_inc     = cnt_reg + 1'b1;

    assign core_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && core_ready;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_data_reg;

    always_comb begin
        busy_next    = busy_reg;
        enabled_next = enabled_reg;
        step_next    = step_reg;
        done_next    = done_reg;
        rev_next     = rev_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        ivl_next     = ivl_reg;
        cdn_next     = cdn_reg;
        accepted     = 1'b0;

        case (action)
            ACT_TICK: begin
                if (busy_reg) begin
                    if (cdn_reg > TIME_WIDTH'(1)) begin
                        cdn_next = cdn_reg - 1'b1;
                    end else if (!step_reg) begin
                        step_next = 1'b1;
                        cdn_next  = pw_t;
                    end else begin
                        step_next = 1'b0;
                        cnt_next  = cnt_inc;
                        if (cnt_inc >= req_reg) begin
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end else if (ivl_reg > pw_t) begin
                            cdn_next = ivl_reg - pw_t;
                        end else begin
                            // Pulse width raised mid-move: no low time left.
                            cdn_next = '0;
                        end
                    end
                end
            end
            ACT_START: begin
                if (!busy_reg && pulse_count != '0 && step_interval > pw_t) begin
                    accepted     = 1'b1;
                    rev_next     = move_reverse;
                    req_next     = pulse_count;
                    cnt_next     = '0;
                    ivl_next     = step_interval;
                    step_next    = 1'b0;
                    done_next    = 1'b0;
                    enabled_next = 1'b1;
                    busy_next    = 1'b1;
                    cdn_next     = enabled_reg ? pw_t : settle_t;
                end
            end
            ACT_STOP: begin
                busy_next = 1'b0;
                step_next = 1'b0;
                done_next = 1'b0;
            end
            ACT_ENABLE: begin
                enabled_next = 1'b1;
            end
            ACT_DISABLE: begin
                if (busy_reg) begin
                    busy_next = 1'b0;
                    done_next = 1'b0;
                end
                step_next    = 1'b0;
                enabled_next = 1'b0;
            end
            ACT_TAKE_DONE: begin
                done_next = 1'b0;
            end
            default: ;
        endcase

        // Taking the flag reports the value it had before clearing.
        done_out = (action == ACT_TAKE_DONE) ? done_reg : done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            enabled_reg <= 1'b0;
            step_reg    <= 1'b0;
            done_reg    <= 1'b0;
            rev_reg     <= 1'b0;
            req_reg     <= '0;
            cnt_reg     <= '0;
            ivl_reg     <= '0;
            cdn_reg     <= '0;
        end else if (take) begin
            busy_reg    <= busy_next;
            enabled_reg <= enabled_next;
            step_reg    <= step_next;
            done_reg    <= done_next;
            rev_reg     <= rev_next;
            req_reg     <= req_next;
            cnt_reg     <= cnt_next;
            ivl_reg     <= ivl_next;
            cdn_reg     <= cdn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_ready) begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= {cnt_next, done_out, accepted, busy_next, enabled_next,
                             cfg.forward_is_high ^ rev_next, step_next};
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Step/direction pulse generator testbench
// Drives command and tick words through the stream input and checks every
// status word against the directed table or an in-bench model of the move
// state machine. The directed table covers refusals, unused codes, a full move,
// stop and disable. Random phases follow, one per register setting, with
// bursty input and receiver stalls, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import sdpg_pkg::*;

    localparam int CNT_W     = 24;
    localparam int TIM_W     = 16;
    localparam int S_W       = ((1 + CNT_W + TIM_W + 7) / 8) * 8;
    localparam int OUT_W     = FLAG_BITS + CNT_W;
    localparam int M_W       = ((OUT_W + 7) / 8) * 8;
    localparam int QUIET_MAX = 4000;
    localparam int HOLD_LEN  = 250;
    localparam int PHASES    = 6;

    // Status word, step_out in bit 0.
    typedef struct packed {
        logic [CNT_W-1:0] steps;
        logic             done;
        logic             acc;
        logic             busy;
        logic             en;
        logic             dir;
        logic             step;
    } status_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic                rev;
        logic [CNT_W-1:0]    cnt;
        logic [TIM_W-1:0]    ivl;
        logic [7:0]          reps;
        logic                typed;
        status_t             want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata = '0;
    logic [ACTION_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_W-1:0]        m_tdata;

    // Model of the move state and of the registers.
    logic             mv_busy, drv_on, mv_high, mv_done, dir_rev;
    logic [CNT_W-1:0] goal, pulses;
    logic [TIM_W-1:0] ivl_r, tmr;
    logic [PW_W-1:0]     cfg_pw;
    logic [SETTLE_W-1:0] cfg_settle;
    logic                cfg_fwd;

    status_t   pending_status[$];
    plan_row_t plan[$];
    status_t   got_word, want_word;

    int errors = 0, commands = 0, words_checked = 0;
    int moves_started = 0, moves_finished = 0, settings_used = 1;
    int quiet = 0, hold_reqs = 0, hold_seen = 0, hold_left = 0;
    int rx_mode = 0, rx_stretch = 0, rx_ctr = 0;

    int phase_pw[PHASES]     = '{1, 3, 0, 2, 255, 4};
    int phase_settle[PHASES] = '{0, 12, 1, 5, 65535, 20};
    int phase_fwd[PHASES]    = '{0, 1, 1, 0, 1, 0};
    int phase_items[PHASES]  = '{80, 80, 80, 80, 40, 80};

    step_dir_pulse_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic status_t status_word(input logic step, input logic dir,
                                            input logic en, input logic busy,
                                            input logic acc, input logic done,
                                            input logic [CNT_W-1:0] steps);
        status_t w;
        w.step  = step;
        w.dir   = dir;
        w.en    = en;
        w.busy  = busy;
        w.acc   = acc;
        w.done  = done;
        w.steps = steps;
        return w;
    endfunction

    // Applies one command to the model and returns the status it produces.
    function automatic status_t next_status(input logic [ACTION_W-1:0] act,
                                            input logic rev,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic [TIM_W-1:0] ivl);
        status_t w;
        logic    took;
        logic    done_seen;
        took = 1'b0;
        case (act)
            ACT_TICK: begin
                if (mv_busy) begin
                    if (tmr > 16'd1) begin
                        tmr = tmr - 16'd1;
                    end else if (!mv_high) begin
                        mv_high = 1'b1;
                        tmr = {8'b0, cfg_pw};
                    end else begin
                        mv_high = 1'b0;
                        pulses = pulses + 24'd1;
                        if (pulses >= goal) begin
                            mv_busy = 1'b0;
                            mv_done = 1'b1;
                            moves_finished++;
                        end else begin
                            // A pulse width at or above the interval leaves no low time.
                            tmr = (ivl_r > {8'b0, cfg_pw}) ? ivl_r - {8'b0, cfg_pw} : 16'd0;
                        end
                    end
                end
            end
            ACT_START: begin
                if (!mv_busy && cnt != '0 && ivl > {8'b0, cfg_pw}) begin
                    dir_rev = rev;
                    goal    = cnt;
                    pulses  = '0;
                    ivl_r   = ivl;
                    mv_high = 1'b0;
                    mv_done = 1'b0;
                    tmr     = drv_on ? {8'b0, cfg_pw} : cfg_settle;
                    drv_on  = 1'b1;
                    mv_busy = 1'b1;
                    took    = 1'b1;
                    moves_started++;
                end
            end
            ACT_STOP: begin
                mv_busy = 1'b0;
                mv_high = 1'b0;
                mv_done = 1'b0;
            end
            ACT_ENABLE: drv_on = 1'b1;
            ACT_DISABLE: begin
                if (mv_busy) begin
                    mv_done = 1'b0;
                end
                mv_busy = 1'b0;
                mv_high = 1'b0;
                drv_on  = 1'b0;
            end
            default: ;
        endcase
        done_seen = mv_done;
        if (act == ACT_TAKE_DONE) begin
            mv_done = 1'b0;
        end
        w = status_word(mv_high, cfg_fwd ^ dir_rev, drv_on, mv_busy, took, done_seen, pulses);
        return w;
    endfunction

    task automatic add_row(input logic [ACTION_W-1:0] act, input logic rev,
                           input logic [CNT_W-1:0] cnt, input logic [TIM_W-1:0] ivl,
                           input logic [7:0] reps, input logic typed, input status_t want);
        plan_row_t r;
        r.act   = act;
        r.rev   = rev;
        r.cnt   = cnt;
        r.ivl   = ivl;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endtask

    // Offers one word and records its expected status once it is taken.
    task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic rev,
                            input logic [CNT_W-1:0] cnt, input logic [TIM_W-1:0] ivl,
                            input logic typed, input status_t want);
        status_t w;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_W - 1 - CNT_W - TIM_W){1'b0}}, ivl, cnt, rev};
        do @(posedge aclk); while (!s_tready);
        w = next_status(act, rev, cnt, ivl);
        pending_status.push_back(typed ? want : w);
        commands++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained;
        pause_sender(1);
        while (pending_status.size() != 0) @(posedge aclk);
    endtask

    // Writes a register with random upper bits, then reads it back.
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
        logic [31:0] data;
        logic [31:0] keep;
        data = $urandom;
        keep = '0;
        case (idx)
            REG_PULSE_WIDTH: begin
                data[PW_W-1:0] = val[PW_W-1:0];
                keep = {24'b0, val[PW_W-1:0]};
                cfg_pw = val[PW_W-1:0];
            end
            REG_SETTLE_TIME: begin
                data[SETTLE_W-1:0] = val;
                keep = {16'b0, val};
                cfg_settle = val;
            end
            default: begin
                data[0] = val[0];
                keep = {31'b0, val[0]};
                cfg_fwd = val[0];
            end
        endcase
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== keep) begin
            errors++;
            $display("%0t: register %0d read back: expected %h, actual %h",
                     $time, idx, keep, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Receiver: stretches of random behavior, overridden by a long hold-off on request.
    always @(negedge aclk) begin
        rx_ctr++;
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_stretch == 0) begin
                rx_mode    = $urandom_range(0, 3);
                rx_stretch = $urandom_range(16, 96);
            end
            rx_stretch--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (rx_ctr % 8) < 4;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word = status_t'(m_tdata[OUT_W-1:0]);
            if (pending_status.size() == 0) begin
                errors++;
                $display("%0t: status word %h arrived with nothing expected", $time, m_tdata);
            end else begin
                want_word = pending_status.pop_front();
                check_field("step_out", int'(want_word.step), int'(got_word.step));
                check_field("dir_out", int'(want_word.dir), int'(got_word.dir));
                check_field("enable_out", int'(want_word.en), int'(got_word.en));
                check_field("busy", int'(want_word.busy), int'(got_word.busy));
                check_field("accepted", int'(want_word.acc), int'(got_word.acc));
                check_field("move_done", int'(want_word.done), int'(got_word.done));
                check_field("steps_done", int'(want_word.steps), int'(got_word.steps));
                words_checked++;
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_MAX) begin
            $display("%0t: no traffic for %0d cycles", $time, QUIET_MAX);
            $display("step_dir_pulse_generator test failed");
            $finish;
        end
    end

    initial begin
        logic [ACTION_W-1:0] act;
        logic                rev;
        logic [CNT_W-1:0]    cnt;
        logic [TIM_W-1:0]    ivl;
        logic [31:0]         rnd;
        int                  burst;
        int                  pick;
        int                  kind;
        status_t             zero_word;

        mv_busy = 1'b0;
        drv_on  = 1'b0;
        mv_high = 1'b0;
        mv_done = 1'b0;
        dir_rev = 1'b0;
        goal    = '0;
        pulses  = '0;
        ivl_r   = '0;
        tmr     = '0;
        cfg_pw     = PW_RESET;
        cfg_settle = SETTLE_RESET;
        cfg_fwd    = FWD_RESET;
        zero_word  = '0;

        // Directed part, run with the register defaults.
        add_row(ACT_TICK, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(ACT_START, 1'b0, 24'd0, 16'd100, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(ACT_START, 1'b1, 24'd4, 16'd5, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(3'd6, 1'b1, '1, '1, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(3'd7, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(ACT_TAKE_DONE, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(ACT_ENABLE, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(ACT_START, 1'b1, 24'd1, 16'd6, 8'd1, 1'b1,
                status_word(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 24'd0));
        add_row(ACT_START, 1'b0, '1, '1, 8'd1, 1'b1,
                status_word(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 24'd0));
        add_row(ACT_TICK, 1'b0, 24'd0, 16'd0, 8'd10, 1'b0, zero_word);
        add_row(ACT_TAKE_DONE, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 24'd1));
        add_row(ACT_TAKE_DONE, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 24'd1));
        add_row(ACT_DISABLE, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd1));
        add_row(ACT_START, 1'b0, '1, '1, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 24'd0));
        add_row(ACT_TICK, 1'b0, 24'd0, 16'd0, 8'd3, 1'b0, zero_word);
        add_row(ACT_STOP, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(ACT_START, 1'b1, 24'd2, 16'd7, 8'd1, 1'b0, zero_word);
        add_row(ACT_TICK, 1'b0, 24'd0, 16'd0, 8'd8, 1'b0, zero_word);
        add_row(ACT_DISABLE, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0));
        add_row(ACT_STOP, 1'b0, 24'd0, 16'd0, 8'd1, 1'b1,
                status_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            for (int k = 0; k < int'(plan[i].reps); k++) begin
                send_cmd(plan[i].act, plan[i].rev, plan[i].cnt, plan[i].ivl,
                         plan[i].typed, plan[i].want);
            end
            pause_sender($urandom_range(0, 2));
        end
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            // A move may still be running here, so new settings also land mid-move.
            set_reg(REG_PULSE_WIDTH, 16'(phase_pw[p]));
            set_reg(REG_SETTLE_TIME, 16'(phase_settle[p]));
            set_reg(REG_FORWARD_IS_HIGH, 16'(phase_fwd[p]));
            settings_used++;
            if (p == 1) begin
                hold_reqs++;
            end
            burst = 0;
            for (int i = 0; i < phase_items[p]; i++) begin
                if (burst == 0) begin
                    pause_sender(($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12));
                    burst = $urandom_range(1, 16);
                end
                burst--;
                rnd  = $urandom;
                rev  = rnd[0];
                cnt  = rnd[CNT_W:1];
                rnd  = $urandom;
                ivl  = rnd[TIM_W-1:0];
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    act = ACT_TICK;
                end else if (pick < 74) begin
                    act  = ACT_START;
                    kind = $urandom_range(0, 19);
                    if (kind < 15) begin
                        // Well-formed move: a few pulses with a short interval.
                        cnt = 24'($urandom_range(1, 6));
                        ivl = 16'(int'(cfg_pw) + $urandom_range(1, 12));
                    end else if (kind < 18) begin
                        cnt = (kind == 15) ? 24'd0 : cnt;
                        ivl = 16'($urandom_range(0, int'(cfg_pw)));
                    end
                end else if (pick < 77) begin
                    act = ACT_STOP;
                end else if (pick < 81) begin
                    act = ACT_ENABLE;
                end else if (pick < 84) begin
                    act = ACT_DISABLE;
                end else if (pick < 94) begin
                    act = ACT_TAKE_DONE;
                end else if (pick < 97) begin
                    act = 3'($urandom_range(6, 7));
                end else begin
                    act = ACT_TICK;
                end
                send_cmd(act, rev, cnt, ivl, 1'b0, zero_word);
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (pending_status.size() != 0) begin
            errors++;
            $display("%0t: %0d status words never arrived", $time, pending_status.size());
        end
        $display("Sent %0d command words under %0d register settings; %0d status words checked.",
                 commands, settings_used, words_checked);
        $display("Moves accepted: %0d, run to their full pulse count: %0d, errors: %0d.",
                 moves_started, moves_finished, errors);
        if (errors == 0) begin
            $display("step_dir_pulse_generator test passed");
        end else begin
            $display("step_dir_pulse_generator test failed");
        end
        $finish;
    end

endmodule
